### sv/iib_pkg.sv
// Shared constants, types and register codes of the integral image builder.
package iib_pkg;

  // Frame size limits and pixel precision
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 16;

  // Fixed field widths of the channels
  localparam int PIXEL_W = 16;
  localparam int SUM_W   = 36;
  localparam int DIM_W   = 11;
  localparam int CFG_IDX_W = 2;

  // Derived widths
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int ROW_SUM_W = PIXEL_BITS + COL_W;
  localparam int CMP_W     = ((DIM_W > COL_W) ? DIM_W : COL_W) + 2;
  localparam int RCMP_W    = ((DIM_W > ROW_W) ? DIM_W : ROW_W) + 2;

  // Queue between front and back; depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  // Reset values of the size registers
  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1024);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1024);

  // One classified pixel, handed from front to back
  typedef struct packed {
    logic [PIXEL_BITS-1:0] pix;
    logic [COL_W-1:0]      col;
    logic                  first_row;
    logic                  end_row;
    logic                  end_frame;
  } iib_item_t;

endpackage

### sv/iib_pixel_if.sv
// Pixel input channel.
interface iib_pixel_if import iib_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

### sv/iib_result_if.sv
// Integral result output channel.
interface iib_result_if import iib_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] integral_sum;
  logic             last_of_frame;

  modport source (output valid, output integral_sum, output last_of_frame, input ready);
  modport sink   (input valid, input integral_sum, input last_of_frame, output ready);
endinterface

### sv/iib_cfg_if.sv
// Configuration write channel.
interface iib_cfg_if import iib_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/iib_front.sv
// Front end: size registers, raster position tracking and pixel classification.
module iib_front import iib_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  iib_pixel_if.sink pixels,
  iib_cfg_if.sink   cfg,
  output logic      push_valid,
  output iib_item_t push_item,
  input  logic      push_ready
);

  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [CMP_W-1:0]  w_eff;
  logic [RCMP_W-1:0] h_eff;
  logic              end_row;
  logic              end_frame;
  logic              accept;

  // Configuration writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_WIDTH:  image_width  <= cfg.data;
        REG_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Effective size: zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (image_width == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(image_width) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(image_width);
    end
    if (image_height == '0) begin
      h_eff = RCMP_W'(1);
    end else if (RCMP_W'(image_height) > RCMP_W'(MAX_HEIGHT)) begin
      h_eff = RCMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = RCMP_W'(image_height);
    end
  end

  // Row and frame boundaries of the current pixel
  assign end_row   = (CMP_W'(col) + CMP_W'(1)) >= w_eff;
  assign end_frame = end_row && ((RCMP_W'(row) + RCMP_W'(1)) >= h_eff);

  assign pixels.ready = push_ready;
  assign accept       = pixels.valid && push_ready;

  // Classified item into the queue
  assign push_valid          = pixels.valid;
  assign push_item.pix       = pixels.pixel[PIXEL_BITS-1:0];
  assign push_item.col       = col;
  assign push_item.first_row = (row == '0);
  assign push_item.end_row   = end_row;
  assign push_item.end_frame = end_frame;

  // Raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (end_row) begin
        col <= '0;
        row <= end_frame ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

### sv/iib_queue.sv
// Short FIFO that decouples the front end from the accumulation back end.
module iib_queue import iib_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  input  iib_item_t push_item,
  output logic      push_ready,
  output logic      pop_valid,
  output iib_item_t pop_item,
  input  logic      pop_ready
);

  iib_item_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/iib_back.sv
// Back end: row accumulator, previous-row line store and output register.
module iib_back import iib_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  input  iib_item_t     pop_item,
  output logic          pop_ready,
  iib_result_if.source  results
);

  logic [SUM_W-1:0]     line_store [MAX_WIDTH];
  logic                 r_valid;
  iib_item_t            r_item;
  logic [SUM_W-1:0]     rdata;
  logic                 fwd_hit;
  logic [SUM_W-1:0]     fwd_data;
  logic [ROW_SUM_W-1:0] row_sum;
  logic [ROW_SUM_W-1:0] row_sum_next;
  logic [SUM_W-1:0]     above;
  logic [SUM_W-1:0]     sum;
  logic                 out_valid;
  logic [SUM_W-1:0]     out_sum;
  logic                 out_last;
  logic                 advance;
  logic                 load;

  // Handshake between read stage and output register
  assign advance   = r_valid && (!out_valid || results.ready);
  assign pop_ready = !r_valid || advance;
  assign load      = pop_valid && pop_ready;

  // Value above: zero on the first row, forwarded when written on the read edge
  always_comb begin
    if (r_item.first_row) begin
      above = '0;
    end else if (fwd_hit) begin
      above = fwd_data;
    end else begin
      above = rdata;
    end
  end

  assign row_sum_next = row_sum + ROW_SUM_W'(r_item.pix);
  assign sum          = SUM_W'(row_sum_next) + above;

  // Line store: write back the finished integral, read the next column
  always_ff @(posedge clk) begin
    if (advance) begin
      line_store[r_item.col] <= sum;
    end
    if (load) begin
      rdata <= line_store[pop_item.col];
    end
  end

  // Read stage payload and forwarding match
  always_ff @(posedge clk) begin
    if (load) begin
      r_item   <= pop_item;
      fwd_hit  <= advance && (r_item.col == pop_item.col);
      fwd_data <= sum;
    end
  end

  // Read stage occupancy and row accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      row_sum <= '0;
    end else begin
      if (load) begin
        r_valid <= 1'b1;
      end else if (advance) begin
        r_valid <= 1'b0;
      end
      if (advance) begin
        row_sum <= r_item.end_row ? '0 : row_sum_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sum  <= sum;
      out_last <= r_item.end_frame;
    end
  end

  assign results.valid         = out_valid;
  assign results.integral_sum  = out_sum;
  assign results.last_of_frame = out_last;

endmodule

### sv/integral_image_builder.sv
// Integral image builder: pixels of one channel enter in raster order and each
// leaves as its summed-area value (sum of all pixels at or above and at or left
// of it), with last_of_frame on the final pixel. One pixel is taken and one
// result given per clock, steady state, while results.ready holds; result valid
// rises after the queue slot, line store read and output register. The rate is
// set by the line store (1024 x 36 bits, one read port and one write port),
// which is read once and written once per pixel; a one-deep forward covers rows
// one pixel wide. Width and height are written through the configuration channel
// (index 0 width, index 1 height); the user must write them only while no pixel
// is in flight (not enforced by the block). A write mid-frame keeps the raster
// position and ends the row or frame at once if the position is already past
// the new size. Zero acts as one and sizes above 1024 clamp. The line store has
// no reset and needs no clearing pass: the first row of each frame ignores it.
module integral_image_builder import iib_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  iib_pixel_if.sink    pixels,
  iib_cfg_if.sink      cfg,
  iib_result_if.source results
);

  logic      push_valid;
  logic      push_ready;
  iib_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  iib_item_t pop_item;

  // Position tracking and classification
  iib_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixels     (pixels),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // Decoupling queue
  iib_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // Accumulation and line store
  iib_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .results   (results)
  );

endmodule
